// ===== rtl/sita_pkg.sv =====
// Shared types and constants for the signed integer to decimal text converter.
// Used by the controller, the datapath and the top level; depends on nothing.
package sita_pkg;

  // Width of the incoming integer and the longest digit run it can produce.
  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_IDX_BITS = $clog2(MAX_DIGITS);
  localparam int CNT_BITS = $clog2(MAX_DIGITS + 1);

  // Division by ten as a multiply by a rounded reciprocal and a right shift.
  // The pair is exact for every unsigned 32-bit dividend.
  localparam int RECIP_SHIFT = 35;
  localparam int PROD_BITS = 2 * VALUE_BITS;
  localparam int QUOT_BITS = PROD_BITS - RECIP_SHIFT;
  localparam logic [VALUE_BITS-1:0] RECIP_TEN = 32'hCCCC_CCCD;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take a new request into the magnitude register
    logic mul;       // form the reciprocal product
    logic div;       // store one digit and keep the quotient
    logic out_load;  // place a character into the output register
    logic out_minus; // the character is the minus sign rather than a digit
  } sita_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quot_zero;  // the quotient formed this cycle is zero
    logic negative;   // the current request is negative
    logic slot_free;  // the output register can take a character this cycle
    logic rd_zero;    // the read pointer sits on the least significant digit
  } sita_status_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal text converter.
// Depends on sita_pkg, sita_ctrl and sita_datapath.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+----------------------
//   input   | in_valid, in_stall  | value[31:0] signed
//   output  | out_valid, out_stall| out_char[7:0], last
//
// A request passes through idle, where it is loaded, then the shared reciprocal
// divider, a multiply step and a quotient and remainder step per decimal digit,
// then the minus sign when negative, and one character per cycle through the
// output register while the output is not stalled.
// Reset is synchronous and clears the controller and the output valid flag.
// A stalled output holds the controller in its emit states until it frees.
module signed_int_to_decimal_ascii_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [sita_pkg::VALUE_BITS-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [7:0]                             out_char,
  output logic                                   last
);
  import sita_pkg::*;

  sita_cmd_t    cmd;
  sita_status_t status;

  sita_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sita_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

`ifndef ASSERT_OFF
  // A new request closes the input until its text is finished.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a conversion was under way");

  // A character is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.slot_free)
    else $error("output register overwritten while stalled");

  // The minus sign never ends a run.
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char == CHAR_MINUS) |-> !last)
    else $error("minus sign flagged as last character");

  // Everything else on the output is a decimal digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_char != CHAR_MINUS) |->
      (out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 8'd9))
    else $error("output character is not a decimal digit");
`endif

endmodule

// ===== rtl/sita_datapath.sv =====
// Datapath: magnitude, reciprocal divider, digit buffer and output register.
// Depends on sita_pkg; driven by sita_ctrl through command and status structs.
module sita_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [sita_pkg::VALUE_BITS-1:0] value,
  input  sita_pkg::sita_cmd_t               cmd,
  output sita_pkg::sita_status_t            status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_char,
  output logic                              last
);
  import sita_pkg::*;

  logic [VALUE_BITS-1:0] mag;
  logic                  negative;
  logic [PROD_BITS-1:0]  prod;
  logic [3:0]            digits [MAX_DIGITS];
  logic [CNT_BITS-1:0]   ndig;
  logic [DIGIT_IDX_BITS-1:0] rd_idx;

  logic [QUOT_BITS-1:0]  quot;
  logic [VALUE_BITS-1:0] quot_wide;
  logic [VALUE_BITS-1:0] rem_wide;
  logic [VALUE_BITS-1:0] abs_value;

  // Magnitude of the request; the most negative value wraps to its own
  // unsigned magnitude, which fits the width.
  assign abs_value = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // Quotient from the registered product, remainder by shift and add.
  assign quot      = prod[PROD_BITS-1:RECIP_SHIFT];
  assign quot_wide = {{(VALUE_BITS-QUOT_BITS){1'b0}}, quot};
  assign rem_wide  = mag - ((quot_wide << 3) + (quot_wide << 1));

  assign status.quot_zero = (quot == '0);
  assign status.negative  = negative;
  assign status.slot_free = !out_valid || !out_stall;
  assign status.rd_zero   = (rd_idx == '0);

  // Magnitude, product and digit buffer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= abs_value;
      negative <= value[VALUE_BITS-1];
      ndig     <= '0;
    end
    if (cmd.mul) begin
      prod <= mag * RECIP_TEN;
    end
    if (cmd.div) begin
      digits[ndig[DIGIT_IDX_BITS-1:0]] <= rem_wide[3:0];
      ndig   <= ndig + 1'b1;
      mag    <= quot_wide;
      rd_idx <= ndig[DIGIT_IDX_BITS-1:0];
    end else if (cmd.out_load && !cmd.out_minus && !status.rd_zero) begin
      rd_idx <= rd_idx - 1'b1;
    end
  end

  // Output register: holds one character until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_minus) begin
        out_char <= CHAR_MINUS;
        last     <= 1'b0;
      end else begin
        out_char <= CHAR_ZERO + {4'h0, digits[rd_idx]};
        last     <= status.rd_zero;
      end
    end
  end

endmodule

// ===== rtl/sita_ctrl.sv =====
// Controller: sequences division steps, the sign and the digit emission.
// Depends on sita_pkg; talks to sita_datapath through command and status structs.
module sita_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  sita_pkg::sita_status_t status,
  output sita_pkg::sita_cmd_t    cmd
);
  import sita_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  // Commands follow from the state and the handshake status.
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (!status.quot_zero) begin
          state_next = S_MUL;
        end else if (status.negative) begin
          state_next = S_SIGN;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_SIGN: begin
        if (status.slot_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_minus = 1'b1;
          state_next    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.out_load = 1'b1;
          if (status.rd_zero) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the signed integer to decimal text converter.
// Drives signed requests, predicts each character run and compares it field by field.
// Depends on sita_pkg and signed_int_to_decimal_ascii_top.
`timescale 1ns / 1ps

module testbench;
  import sita_pkg::*;

  localparam int RANDOM_REQUESTS = 287;
  localparam int STALL_PERCENT = 21;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 50;
  localparam int NO_PROGRESS_LIMIT = 3000;

  // One expected character of a number's text.
  typedef struct packed {
    logic [7:0] glyph;
    logic       is_last;
  } text_char_t;

  // A directed request; an empty text means the predictor supplies the run.
  typedef struct {
    int    number;
    string text;
  } directed_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [VALUE_BITS-1:0]  value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_char;
  logic                          last;

  text_char_t pending_chars[$];
  int         mismatch_count = 0;
  int         requests_taken = 0;
  int         quiet_cycles = 0;
  bit         steady = 1'b0;
  bit         hold_done = 1'b0;

  directed_row_t directed_rows[23] = '{
    '{0, "0"},
    '{1, "1"},
    '{-1, "-1"},
    '{9, "9"},
    '{-9, "-9"},
    '{10, "10"},
    '{-10, "-10"},
    '{2147483647, "2147483647"},
    '{-2147483648, "-2147483648"},
    '{-2147483647, "-2147483647"},
    '{1000000000, "1000000000"},
    '{-1000000000, "-1000000000"},
    '{999999999, "999999999"},
    '{100, ""},
    '{1234567890, ""},
    '{-1234567890, ""},
    '{32'h5555_5555, ""},
    '{32'hAAAA_AAAA, ""},
    '{65535, ""},
    '{-65536, ""},
    '{12345, ""},
    '{-7, ""},
    '{32'h7FFF_0000, ""}
  };

  signed_int_to_decimal_ascii_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint power_of_ten(input int exponent);
    longint result;
    result = 1;
    for (int i = 0; i < exponent; i++) result *= 10;
    return result;
  endfunction

  // Works out the decimal text of a number and queues its characters.
  function automatic void predict_text(input logic signed [VALUE_BITS-1:0] number);
    longint      magnitude;
    byte unsigned digit_buf[10];
    int          n_digits;
    magnitude = number;
    if (number < 0) magnitude = -magnitude;
    n_digits = 0;
    do begin
      digit_buf[n_digits] = byte'(magnitude % 10);
      magnitude = magnitude / 10;
      n_digits++;
    end while (magnitude != 0);
    if (number < 0) pending_chars.push_back(text_char_t'{CHAR_MINUS, 1'b0});
    for (int k = n_digits - 1; k >= 0; k--) begin
      pending_chars.push_back(text_char_t'{CHAR_ZERO + digit_buf[k], k == 0});
    end
  endfunction

  // Queues a run that was written out by hand.
  function automatic void queue_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back(text_char_t'{text[i], i == text.len() - 1});
    end
  endfunction

  // Draws a request from a mix of classes so that every digit count is reached.
  function automatic logic signed [VALUE_BITS-1:0] draw_number();
    int     kind;
    int     digits;
    longint lo;
    longint hi;
    longint magnitude;
    bit     negate;
    kind = $urandom_range(0, 5);
    negate = $urandom_range(0, 1);
    case (kind)
      0, 1: begin
        return $urandom;
      end
      2: begin
        digits = $urandom_range(1, 10);
        lo = power_of_ten(digits - 1);
        hi = power_of_ten(digits) - 1;
        if (hi > 2147483647) hi = 2147483647;
        magnitude = lo + longint'($urandom_range(0, 32'(hi - lo)));
      end
      3: begin
        magnitude = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
      end
      4: begin
        if (negate) return 32'sh8000_0000 + $urandom_range(0, 20);
        return 32'sh7FFF_FFFF - $urandom_range(0, 20);
      end
      default: begin
        magnitude = $urandom_range(0, 99);
      end
    endcase
    return 32'(negate ? -magnitude : magnitude);
  endfunction

  // Offers one request, after a random gap or a full drain, and waits for it
  // to be taken. Called at a falling edge and returns at a falling edge.
  task automatic offer(input logic signed [VALUE_BITS-1:0] number, input string text,
                       input bit drain);
    int gap;
    gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < STALL_PERCENT) gap++;
    end
    if ((gap > 0 || (drain && pending_chars.size() != 0)) && in_valid) in_valid <= 1'b0;
    repeat (gap) @(negedge clk);
    if (drain) begin
      while (pending_chars.size() != 0) @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= number;
    do @(posedge clk); while (in_stall);
    if (text.len() > 0) queue_text(text);
    else predict_text(number);
    requests_taken++;
    @(negedge clk);
  endtask

  // Sender: directed table, then random requests.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].number, directed_rows[i].text, 1'b0);
    end
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      steady = (i >= 200 && i < 260);
      offer(draw_number(), "", i == 100);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $error("%0d expected characters never arrived", pending_chars.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off once 40 requests have been taken.
  initial begin
    @(negedge clk);
    forever begin
      if (!hold_done && requests_taken >= 40) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= steady ? 1'b0 : ($urandom_range(99) < STALL_PERCENT);
      @(negedge clk);
    end
  end

  // Compares each accepted character with the oldest expectation.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: out_char %h, last %b", out_char, last);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.glyph) begin
          $error("out_char: expected %h, actual %h", want.glyph, out_char);
          mismatch_count++;
        end
        if (last !== want.is_last) begin
          $error("last: expected %b, actual %b", want.is_last, last);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= NO_PROGRESS_LIMIT) begin
      $display("timeout: no request or character moved for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ===== signed_int_to_decimal_ascii_top.f =====
rtl/sita_pkg.sv
rtl/sita_datapath.sv
rtl/sita_ctrl.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/testbench.sv
